>>> sv/sra_pkg.sv
// ----------------------------------------------------------------------------
// sra_pkg: shared types and constants for the spawn rate accumulator
// Holds the transaction structs, the sequencer states, the remainder unit
// handshake structs and the fixed field widths.
// ----------------------------------------------------------------------------
package sra_pkg;

	localparam int BURST_SLOTS_DEF = 4;

	localparam int CMD_W     = 1;
	localparam int TIME_W    = 32;
	localparam int RATE_W    = 32;
	localparam int POOL_W    = 16;
	localparam int BURSTS_W  = 3;
	localparam int SLOT_W    = 64;
	localparam int COUNT_W   = 16;
	localparam int FRAC_W    = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 64;

	// Accumulator: fraction + (product >> 16) + up to four 32-bit counts.
	localparam int ACC_W     = 49;
	localparam int WHOLE_W   = ACC_W - FRAC_W;

	// Radix-4 multiply: two multiplier bits per step.
	localparam int MUL_STEPS = RATE_W / 2;
	localparam int STEP_W    = $clog2(MUL_STEPS);

	// Remainder unit: dividend is ring offset plus count.
	localparam int DIVIDEND_W = POOL_W + 1;
	localparam int MOD_CNT_W  = $clog2(DIVIDEND_W + 1);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_DYNAMIC_ENABLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPAWN_RATE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BURSTS_IN_USE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BURST_SLOT_0   = 3'd4;

	// Input commands.
	localparam logic [CMD_W-1:0] CMD_TICK    = 1'b0;
	localparam logic [CMD_W-1:0] CMD_RESTART = 1'b1;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [TIME_W-1:0] delta_time;
	} sra_tick_t;

	typedef struct packed {
		logic [COUNT_W-1:0] spawn_count;
		logic [POOL_W-1:0]  spawn_start;
		logic [POOL_W-1:0]  next_start;
		logic               count_saturated;
	} sra_result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ACC,
		ST_BURST,
		ST_SAT,
		ST_MOD,
		ST_DONE
	} sra_state_t;

	typedef struct packed {
		logic start;
	} sra_mod_ctl_t;

	typedef struct packed {
		logic done;
	} sra_mod_status_t;

endpackage

>>> sv/spawn_rate_accumulator.sv
// ----------------------------------------------------------------------------
// spawn_rate_accumulator: fractional spawn rate accumulator with timed bursts
// Per-frame tick in, spawn count and ring offsets out; time and rate in UQ16.16.
// ----------------------------------------------------------------------------
// A tick transaction with dynamic mode on passes through these steps from
// accept to a valid result: the radix-4 shift-add multiplier (delta_time
// times spawn_rate, two rate bits per cycle), a fold of the product into
// the accumulator, a scan of the burst slots (BURST_SLOTS) for the
// start-time compare and count add, a state that saturates the count and
// launches the remainder unit, the bit-serial remainder unit that wraps
// the ring offset by pool_size, and a state that loads the output register.
// The input opens again once the sequencer is back in idle. A restart, or
// a tick while dynamic mode is off, goes straight from accept to the
// output register load. The block accepts one transaction at a time
// (tick_ready is high only when the sequencer is idle). The result sits
// in an output register, so the next tick can be accepted while the
// previous result still waits on result_ready. A transaction that
// finishes while that register is still full holds until the register
// drains. Configuration writes must only be issued while no transaction
// is in flight.
// ----------------------------------------------------------------------------
module spawn_rate_accumulator #(
	parameter int BURST_SLOTS = sra_pkg::BURST_SLOTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           tick_valid,
	output logic                           tick_ready,
	input  sra_pkg::sra_tick_t             tick,
	output logic                           result_valid,
	input  logic                           result_ready,
	output sra_pkg::sra_result_t           result,
	input  logic                           cfg_wen,
	input  logic [sra_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [sra_pkg::CFG_W-1:0]      cfg_wdata
);
	import sra_pkg::*;

	localparam int BIDX_W = (BURST_SLOTS > 1) ? $clog2(BURST_SLOTS) : 1;

	// Configuration registers.
	logic                  dyn_en_q;
	logic [RATE_W-1:0]     rate_q;
	logic [POOL_W-1:0]     pool_q;
	logic [BURSTS_W-1:0]   bursts_q;
	logic [SLOT_W-1:0]     slot_q [BURST_SLOTS];

	// Block state.
	logic [TIME_W-1:0]      elapsed_q;
	logic [FRAC_W-1:0]      frac_q;
	logic [BURST_SLOTS-1:0] fired_q;
	logic [POOL_W-1:0]      ring_q;

	// Per-transaction working registers.
	sra_state_t          state_q, state_d;
	logic [STEP_W-1:0]   step_q;
	logic [TIME_W-1:0]   delta_q;
	logic [TIME_W-1:0]   prod_hi_q;
	logic [RATE_W-1:0]   prod_lo_q;
	logic [ACC_W-1:0]    acc_q;
	logic [COUNT_W-1:0]  count_q;
	logic [POOL_W-1:0]   next_q;
	logic                sat_q;

	// Output register.
	logic                result_valid_q;
	sra_result_t         result_q;

	// Handshake and control decode.
	logic                tick_acc;
	logic                live_tick;
	logic                mul_last;
	logic                burst_last;
	logic                load_result;
	sra_mod_ctl_t        mod_ctl;
	sra_mod_status_t     mod_status;

	// Datapath wires.
	logic [TIME_W:0]      elapsed_sum;
	logic [TIME_W+1:0]    partial;
	logic [TIME_W+1:0]    prod_step;
	logic [BIDX_W-1:0]    bidx;
	logic [SLOT_W-1:0]    bslot;
	logic                 bhit;
	logic [WHOLE_W-1:0]   whole;
	logic [COUNT_W-1:0]   count_sat;
	logic                 whole_ovf;
	logic [DIVIDEND_W-1:0] dividend;
	logic [POOL_W-1:0]    pool_eff;
	logic [POOL_W-1:0]    mod_rem;

	assign tick_acc   = tick_valid && tick_ready;
	assign live_tick  = (tick.command == CMD_TICK) && dyn_en_q;
	assign mul_last   = (step_q == STEP_W'(MUL_STEPS - 1));
	assign burst_last = (step_q == STEP_W'(BURST_SLOTS - 1));

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (tick_acc) begin
					state_d = live_tick ? ST_MUL : ST_DONE;
				end
			end
			ST_MUL: begin
				if (mul_last) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC:   state_d = ST_BURST;
			ST_BURST: begin
				if (burst_last) begin
					state_d = ST_SAT;
				end
			end
			ST_SAT:   state_d = ST_MOD;
			ST_MOD: begin
				if (mod_status.done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (load_result) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		tick_ready    = 1'b0;
		mod_ctl.start = 1'b0;
		load_result   = 1'b0;
		case (state_q)
			ST_IDLE: tick_ready    = 1'b1;
			ST_SAT:  mod_ctl.start = 1'b1;
			ST_DONE: load_result   = !result_valid_q || result_ready;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration writes; indexes past the last burst slot are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dyn_en_q <= 1'b0;
			rate_q   <= '0;
			pool_q   <= POOL_W'(1);
			bursts_q <= '0;
			for (int i = 0; i < BURST_SLOTS; i++) begin
				slot_q[i] <= '0;
			end
		end else if (cfg_wen) begin
			case (cfg_idx)
				REG_DYNAMIC_ENABLE: dyn_en_q <= cfg_wdata[0];
				REG_SPAWN_RATE:     rate_q   <= cfg_wdata[RATE_W-1:0];
				REG_POOL_SIZE:      pool_q   <= cfg_wdata[POOL_W-1:0];
				REG_BURSTS_IN_USE:  bursts_q <= cfg_wdata[BURSTS_W-1:0];
				default: begin
					for (int i = 0; i < BURST_SLOTS; i++) begin
						if (cfg_idx == CFG_IDX_W'(int'(REG_BURST_SLOT_0) + i)) begin
							slot_q[i] <= cfg_wdata;
						end
					end
				end
			endcase
		end
	end

	// Elapsed time saturates at all ones.
	assign elapsed_sum = {1'b0, elapsed_q} + {1'b0, tick.delta_time};

	// Radix-4 multiply step: add digit times delta to the high half, shift by two.
	always_comb begin
		partial   = ({(TIME_W+2){prod_lo_q[0]}} & {2'b00, delta_q})
			+ ({(TIME_W+2){prod_lo_q[1]}} & {1'b0, delta_q, 1'b0});
		prod_step = {2'b00, prod_hi_q} + partial;
	end

	// Burst scan: one slot per cycle, fire if active, unfired and already due.
	assign bidx  = step_q[BIDX_W-1:0];
	assign bslot = slot_q[bidx];
	assign bhit  = ({{(BURSTS_W-BIDX_W){1'b0}}, bidx} < bursts_q) && !fired_q[bidx]
		&& (bslot[SLOT_W-1:TIME_W] < elapsed_q);

	// Whole part saturates at the count width; the fraction is kept.
	assign whole     = acc_q[ACC_W-1:FRAC_W];
	assign whole_ovf = |whole[WHOLE_W-1:COUNT_W];
	assign count_sat = whole_ovf ? {COUNT_W{1'b1}} : whole[COUNT_W-1:0];
	assign dividend  = {1'b0, ring_q} + {1'b0, count_sat};
	assign pool_eff  = (pool_q == '0) ? POOL_W'(1) : pool_q;

	sra_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (mod_ctl),
		.dividend  (dividend),
		.divisor   (pool_eff),
		.status    (mod_status),
		.remainder (mod_rem)
	);

	// Control state: time, fraction, fired marks, ring offset, step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			frac_q    <= '0;
			fired_q   <= '0;
			ring_q    <= '0;
			step_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (tick_acc) begin
						if (tick.command == CMD_RESTART) begin
							elapsed_q <= '0;
							frac_q    <= '0;
							fired_q   <= '0;
						end else if (dyn_en_q) begin
							elapsed_q <= elapsed_sum[TIME_W] ? {TIME_W{1'b1}}
								: elapsed_sum[TIME_W-1:0];
						end
					end
				end
				ST_MUL: begin
					step_q <= mul_last ? '0 : step_q + 1'b1;
				end
				ST_BURST: begin
					step_q <= step_q + 1'b1;
					if (bhit) begin
						fired_q[bidx] <= 1'b1;
					end
				end
				ST_SAT: begin
					frac_q <= acc_q[FRAC_W-1:0];
				end
				ST_DONE: begin
					if (load_result) begin
						ring_q <= next_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Working payload registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (tick_acc) begin
					delta_q   <= tick.delta_time;
					prod_hi_q <= '0;
					prod_lo_q <= rate_q;
					acc_q     <= {{(ACC_W-FRAC_W){1'b0}}, frac_q};
					count_q   <= '0;
					next_q    <= ring_q;
					sat_q     <= live_tick && elapsed_sum[TIME_W];
				end
			end
			ST_MUL: begin
				prod_hi_q <= prod_step[TIME_W+1:2];
				prod_lo_q <= {prod_step[1:0], prod_lo_q[RATE_W-1:2]};
			end
			ST_ACC: begin
				// Fold in the product floored to 16 fraction bits.
				acc_q <= acc_q + {1'b0, prod_hi_q, prod_lo_q[RATE_W-1:FRAC_W]};
			end
			ST_BURST: begin
				if (bhit) begin
					acc_q <= acc_q + {{(ACC_W-TIME_W){1'b0}}, bslot[TIME_W-1:0]};
				end
			end
			ST_SAT: begin
				count_q <= count_sat;
				sat_q   <= sat_q || whole_ovf;
			end
			ST_MOD: begin
				if (mod_status.done) begin
					next_q <= mod_rem;
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: hold the result until result_ready takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load_result) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_result) begin
			result_q.spawn_count     <= count_q;
			result_q.spawn_start     <= ring_q;
			result_q.next_start      <= next_q;
			result_q.count_saturated <= sat_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

>>> sv/sra_mod.sv
// ----------------------------------------------------------------------------
// sra_mod: iterative remainder unit
// Restoring remainder, one dividend bit per cycle; a done pulse flags the
// cycle in which the remainder is valid.
// ----------------------------------------------------------------------------
module sra_mod (
	input  logic                               clk,
	input  logic                               arst_n,
	input  sra_pkg::sra_mod_ctl_t              ctl,
	input  logic [sra_pkg::DIVIDEND_W-1:0]     dividend,
	input  logic [sra_pkg::POOL_W-1:0]         divisor,
	output sra_pkg::sra_mod_status_t           status,
	output logic [sra_pkg::POOL_W-1:0]         remainder
);
	import sra_pkg::*;

	logic [MOD_CNT_W-1:0]  cnt_q;
	logic                  done_q;
	logic [DIVIDEND_W-1:0] x_q;
	logic [POOL_W-1:0]     div_q;
	logic [POOL_W-1:0]     rem_q;
	logic [POOL_W:0]       trial;
	logic [POOL_W:0]       reduced;

	always_comb begin
		trial = {rem_q, x_q[DIVIDEND_W-1]};
		if (trial >= {1'b0, div_q}) begin
			reduced = trial - {1'b0, div_q};
		end else begin
			reduced = trial;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				cnt_q <= MOD_CNT_W'(DIVIDEND_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == MOD_CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			x_q   <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			x_q   <= {x_q[DIVIDEND_W-2:0], 1'b0};
			rem_q <= reduced[POOL_W-1:0];
		end
	end

	assign status.done = done_q;
	assign remainder   = rem_q;

endmodule

>>> tb/tb_spawn_rate_accumulator.sv
// ----------------------------------------------------------------------------
// tb_spawn_rate_accumulator: self-checking bench for the spawn rate accumulator
// Drives tick and restart transactions through a valid/ready channel, mirrors
// the block in a local predictor (elapsed time, spawn fraction, burst marks,
// ring offset) and checks every result field against the predicted or hand-typed batch.
// A short directed table covers the corner cases, then random phases with
// their own register settings and idling (none in the fifth), and once one long stall.
// ----------------------------------------------------------------------------
module tb_spawn_rate_accumulator;
	timeunit 1ns;
	timeprecision 1ps;

	import sra_pkg::*;

	// One row of the directed table: a register write or a transaction,
	// optionally with the result typed in by hand.
	typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_W-1:0]      data;
		sra_tick_t             item;
		bit                    known;
		sra_result_t           known_res;
	} plan_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  tick_valid = 1'b0;
	logic                  tick_ready;
	sra_tick_t             tick = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	sra_result_t           result;
	logic                  cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [CFG_W-1:0]      cfg_wdata = '0;

	// Register mirror used by the predictor.
	logic                  cfg_dynamic;
	logic [RATE_W-1:0]     cfg_rate;
	logic [POOL_W-1:0]     cfg_pool;
	logic [BURSTS_W-1:0]   cfg_bursts;
	logic [SLOT_W-1:0]     cfg_slot [BURST_SLOTS_DEF];

	// Predictor state.
	logic [TIME_W-1:0]     elapsed_acc;
	logic [FRAC_W-1:0]     frac_acc;
	logic                  burst_done [BURST_SLOTS_DEF];
	logic [POOL_W-1:0]     ring_pos;

	sra_result_t           predicted_batches [$];
	plan_row_t             plan [$];
	int                    fault_count = 0;
	int                    results_seen = 0;
	bit                    no_gaps = 1'b0;

	spawn_rate_accumulator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick_valid   (tick_valid),
		.tick_ready   (tick_ready),
		.tick         (tick),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_wen      (cfg_wen),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata)
	);

	always #6 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor: advance the mirrored state by one transaction and return
	// the batch the block should report for it.
	// ------------------------------------------------------------------
	function automatic sra_result_t predict_batch(input sra_tick_t t);
		sra_result_t r;
		logic [TIME_W:0] sum;
		logic [63:0] acc;
		logic [63:0] whole;
		logic [POOL_W:0] pool;
		logic [POOL_W:0] wrapped;
		int active;
		int i;
		r = '0;
		r.spawn_start = ring_pos;
		r.next_start = ring_pos;
		if (t.command == CMD_RESTART) begin
			// Clear time, fraction and burst marks; the ring offset survives.
			elapsed_acc = '0;
			frac_acc = '0;
			for (i = 0; i < BURST_SLOTS_DEF; i++)
				burst_done[i] = 1'b0;
			return r;
		end
		// Dynamic mode off: the tick leaves every bit of state alone.
		if (!cfg_dynamic)
			return r;

		// Saturate elapsed time at all ones.
		sum = {1'b0, elapsed_acc} + {1'b0, t.delta_time};
		if (sum[TIME_W]) begin
			elapsed_acc = '1;
			r.count_saturated = 1'b1;
		end else begin
			elapsed_acc = sum[TIME_W-1:0];
		end

		// Floor the exact product to 16 fraction bits before accumulating.
		acc = 64'(frac_acc) + ((64'(t.delta_time) * 64'(cfg_rate)) >> FRAC_W);

		// Clamp the slot count to the slots that exist.
		active = (cfg_bursts > BURST_SLOTS_DEF) ? BURST_SLOTS_DEF : int'(cfg_bursts);
		for (i = 0; i < active; i++) begin
			if (!burst_done[i] && cfg_slot[i][63:32] < elapsed_acc) begin
				acc += 64'(cfg_slot[i][31:0]);
				burst_done[i] = 1'b1;
			end
		end

		// Keep the fraction; drop any whole part above the count limit.
		frac_acc = acc[FRAC_W-1:0];
		whole = acc >> FRAC_W;
		if (whole > 64'hFFFF) begin
			r.spawn_count = '1;
			r.count_saturated = 1'b1;
		end else begin
			r.spawn_count = whole[COUNT_W-1:0];
		end

		// A zero pool size behaves as a pool of one.
		pool = (cfg_pool == '0) ? 17'd1 : {1'b0, cfg_pool};
		wrapped = ({1'b0, ring_pos} + {1'b0, r.spawn_count}) % pool;
		ring_pos = wrapped[POOL_W-1:0];
		r.next_start = ring_pos;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Directed table helpers.
	// ------------------------------------------------------------------
	function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] data);
		plan_row_t r;
		r.kind = ROW_WRITE;
		r.idx = idx;
		r.data = data;
		r.item = '0;
		r.known = 1'b0;
		r.known_res = '0;
		return r;
	endfunction

	function automatic plan_row_t item_row(input logic [CMD_W-1:0] cmd,
			input logic [TIME_W-1:0] delta);
		plan_row_t r;
		r = reg_row(REG_DYNAMIC_ENABLE, '0);
		r.kind = ROW_ITEM;
		r.item.command = cmd;
		r.item.delta_time = delta;
		return r;
	endfunction

	function automatic plan_row_t known_row(input logic [CMD_W-1:0] cmd,
			input logic [TIME_W-1:0] delta, input logic [COUNT_W-1:0] count,
			input logic [POOL_W-1:0] start, input logic [POOL_W-1:0] next,
			input logic sat);
		plan_row_t r;
		r = item_row(cmd, delta);
		r.known = 1'b1;
		r.known_res.spawn_count = count;
		r.known_res.spawn_start = start;
		r.known_res.next_start = next;
		r.known_res.count_saturated = sat;
		return r;
	endfunction

	// Append one row to the end of the directed table.
	function automatic void add_row(input plan_row_t r);
		plan.insert(plan.size(), r);
	endfunction

	// ------------------------------------------------------------------
	// Mismatch reporting and result checking.
	// ------------------------------------------------------------------
	task automatic flag_mismatch(input string field, input logic [15:0] seen,
			input logic [15:0] want);
		fault_count++;
		$display("%0t ns: result %0d %s is 0x%0h, predicted 0x%0h",
			$time, results_seen, field, seen, want);
	endtask

	task automatic check_result(input sra_result_t got);
		sra_result_t want;
		if (predicted_batches.size() == 0) begin
			flag_mismatch("unexpected transaction, spawn_count", got.spawn_count, '0);
		end else begin
			want = predicted_batches.pop_front();
			if (got.spawn_count !== want.spawn_count)
				flag_mismatch("spawn_count", got.spawn_count, want.spawn_count);
			if (got.spawn_start !== want.spawn_start)
				flag_mismatch("spawn_start", got.spawn_start, want.spawn_start);
			if (got.next_start !== want.next_start)
				flag_mismatch("next_start", got.next_start, want.next_start);
			if (got.count_saturated !== want.count_saturated)
				flag_mismatch("count_saturated", 16'(got.count_saturated),
					16'(want.count_saturated));
		end
		results_seen++;
	endtask

	// ------------------------------------------------------------------
	// Sender side. Every task starts and ends on a rising-edge time step,
	// and none assigns tick_valid twice in one step.
	// ------------------------------------------------------------------

	// Write one register and mirror it. Only call while the block is idle.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_wen <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		case (idx)
			REG_DYNAMIC_ENABLE: cfg_dynamic = data[0];
			REG_SPAWN_RATE:     cfg_rate = data[RATE_W-1:0];
			REG_POOL_SIZE:      cfg_pool = data[POOL_W-1:0];
			REG_BURSTS_IN_USE:  cfg_bursts = data[BURSTS_W-1:0];
			default:            cfg_slot[2'(idx - REG_BURST_SLOT_0)] = data;
		endcase
		@(posedge clk);
		cfg_wen <= 1'b0;
		@(posedge clk);
	endtask

	// Offer one transaction and hold it until accepted; predict on accept.
	// Valid stays high on return so back-to-back items need no dip.
	task automatic send_item(input sra_tick_t t, input bit known,
			input sra_result_t known_res);
		sra_result_t want;
		tick <= t;
		tick_valid <= 1'b1;
		do
			@(posedge clk);
		while (!tick_ready);
		want = predict_batch(t);
		predicted_batches.insert(predicted_batches.size(), known ? known_res : want);
	endtask

	// Drop valid for a random gap now and then.
	task automatic pace();
		if (!no_gaps && $urandom_range(99) < 13) begin
			tick_valid <= 1'b0;
			repeat ($urandom_range(1, 50)) @(posedge clk);
		end
	endtask

	// Drop valid, step past this edge and wait until every predicted batch
	// has come back.
	task automatic settle();
		tick_valid <= 1'b0;
		do
			@(posedge clk);
		while (predicted_batches.size() != 0);
	endtask

	// One random phase: a fresh (partial) register setting, then n items.
	task automatic run_phase(input int n, input bit all_regs);
		sra_tick_t t;
		logic [31:0] at, amount;
		logic [RATE_W-1:0] rate;
		logic [POOL_W-1:0] pool;
		int i;
		settle();
		if (all_regs || $urandom_range(99) < 70)
			write_reg(REG_DYNAMIC_ENABLE, CFG_W'($urandom_range(99) < 85));
		if (all_regs || $urandom_range(99) < 70) begin
			case ($urandom_range(9))
				0:       rate = '0;
				1:       rate = '1;
				2, 3:    rate = $urandom;
				default: rate = $urandom_range(0, 32'h0040_0000);
			endcase
			write_reg(REG_SPAWN_RATE, CFG_W'(rate));
		end
		if (all_regs || $urandom_range(99) < 70) begin
			case ($urandom_range(9))
				0:       pool = '0;
				1:       pool = 16'd1;
				2:       pool = '1;
				3:       pool = 16'($urandom_range(0, 65535));
				default: pool = 16'($urandom_range(1, 20));
			endcase
			write_reg(REG_POOL_SIZE, CFG_W'(pool));
		end
		if (all_regs || $urandom_range(99) < 70)
			write_reg(REG_BURSTS_IN_USE, CFG_W'($urandom_range(0, 7)));
		for (i = 0; i < BURST_SLOTS_DEF; i++) begin
			if (all_regs || $urandom_range(99) < 70) begin
				// Mostly start times a few seconds in, so bursts fire mid-phase.
				at = ($urandom_range(99) < 80) ? $urandom_range(0, 32'h0010_0000) : $urandom;
				amount = ($urandom_range(99) < 80) ? $urandom_range(0, 32'h0020_0000)
					: $urandom;
				write_reg(CFG_IDX_W'(REG_BURST_SLOT_0 + i), {at, amount});
			end
		end
		repeat (n) begin
			t.command = ($urandom_range(99) < 8) ? CMD_RESTART : CMD_TICK;
			// Mostly frame-sized deltas; a few extremes and wide values.
			case ($urandom_range(19))
				0:          t.delta_time = '0;
				1:          t.delta_time = '1;
				2, 3:       t.delta_time = $urandom;
				4, 5, 6, 7: t.delta_time = $urandom_range(0, 32'h000F_FFFF);
				default:    t.delta_time = $urandom_range(0, 32'h0000_4000);
			endcase
			pace();
			send_item(t, 1'b0, '0);
		end
	endtask

	// ------------------------------------------------------------------
	// Main stimulus.
	// ------------------------------------------------------------------
	initial begin
		int done_items;
		int phase_no;
		int n;
		int i;

		// Mirror the register reset values.
		cfg_dynamic = 1'b0;
		cfg_rate = '0;
		cfg_pool = 16'd1;
		cfg_bursts = '0;
		elapsed_acc = '0;
		frac_acc = '0;
		ring_pos = '0;
		for (i = 0; i < BURST_SLOTS_DEF; i++) begin
			cfg_slot[i] = '0;
			burst_done[i] = 1'b0;
		end

		// Reset values: a tick with dynamic mode off, then a restart.
		add_row(known_row(CMD_TICK, 32'hFFFF_FFFF, 16'd0, 16'd0, 16'd0, 1'b0));
		add_row(known_row(CMD_RESTART, 32'h0000_0000, 16'd0, 16'd0, 16'd0, 1'b0));
		// Rate of one per second into a ring of ten.
		add_row(reg_row(REG_DYNAMIC_ENABLE, 64'd1));
		add_row(reg_row(REG_SPAWN_RATE, 64'h0001_0000));
		add_row(reg_row(REG_POOL_SIZE, 64'd10));
		add_row(reg_row(REG_BURSTS_IN_USE, 64'd0));
		add_row(known_row(CMD_TICK, 32'h0002_8000, 16'd2, 16'd0, 16'd2, 1'b0));
		add_row(item_row(CMD_TICK, 32'h0000_8000));
		add_row(item_row(CMD_TICK, 32'h0000_0000));
		// Full-scale rate and delta: elapsed time and count both saturate.
		add_row(reg_row(REG_SPAWN_RATE, 64'hFFFF_FFFF));
		add_row(item_row(CMD_TICK, 32'hFFFF_FFFF));
		add_row(item_row(CMD_TICK, 32'h0000_0001));
		add_row(item_row(CMD_RESTART, 32'hFFFF_FFFF));
		// Bursts only, largest pool. Slot 2 starts at the last instant and
		// never fires, since the start compare is strict.
		add_row(reg_row(REG_SPAWN_RATE, 64'd0));
		add_row(reg_row(REG_POOL_SIZE, 64'hFFFF));
		add_row(reg_row(REG_BURSTS_IN_USE, 64'd4));
		add_row(reg_row(REG_BURST_SLOT_0, {32'h0000_0000, 32'h0001_0000}));
		add_row(reg_row(REG_BURST_SLOT_0 + 3'd1, {32'h0001_0000, 32'h0003_0000}));
		add_row(reg_row(REG_BURST_SLOT_0 + 3'd2, {32'hFFFF_FFFF, 32'hFFFF_FFFF}));
		add_row(reg_row(REG_BURST_SLOT_0 + 3'd3, {32'h0000_8000, 32'h0000_8000}));
		add_row(item_row(CMD_TICK, 32'h0000_0000));
		add_row(item_row(CMD_TICK, 32'h0000_8000));
		add_row(item_row(CMD_TICK, 32'h0000_0001));
		add_row(item_row(CMD_TICK, 32'h0001_0000));
		add_row(item_row(CMD_TICK, 32'h0001_0000));
		add_row(item_row(CMD_RESTART, 32'h0000_0000));
		add_row(item_row(CMD_TICK, 32'hFFFF_FFFF));
		// Too many bursts in use, zero pool, burst counts that overflow.
		add_row(reg_row(REG_BURSTS_IN_USE, 64'd7));
		add_row(reg_row(REG_POOL_SIZE, 64'd0));
		add_row(reg_row(REG_BURST_SLOT_0, {32'h0000_0000, 32'hFFFF_FFFF}));
		add_row(reg_row(REG_BURST_SLOT_0 + 3'd2, {32'h0000_0000, 32'hFFFF_FFFF}));
		add_row(item_row(CMD_RESTART, 32'h0000_0000));
		add_row(item_row(CMD_TICK, 32'h0000_0001));
		// Pool of seven with the offset at zero, half-rate, two slots.
		add_row(reg_row(REG_POOL_SIZE, 64'd7));
		add_row(reg_row(REG_BURSTS_IN_USE, 64'd2));
		add_row(reg_row(REG_SPAWN_RATE, 64'h0000_8000));
		add_row(item_row(CMD_RESTART, 32'h0000_0000));
		add_row(item_row(CMD_TICK, 32'h0003_0000));
		// Dynamic mode off with a non-zero ring offset.
		add_row(reg_row(REG_DYNAMIC_ENABLE, 64'd0));
		add_row(item_row(CMD_TICK, 32'h1234_5678));
		// Tiny rate: the second tick's product floors away below one fraction LSB.
		add_row(reg_row(REG_DYNAMIC_ENABLE, 64'd1));
		add_row(reg_row(REG_BURSTS_IN_USE, 64'd0));
		add_row(reg_row(REG_SPAWN_RATE, 64'h0000_0001));
		add_row(reg_row(REG_POOL_SIZE, 64'd3));
		add_row(item_row(CMD_TICK, 32'h8000_0000));
		add_row(item_row(CMD_TICK, 32'h0000_FFFF));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table.
		foreach (plan[k]) begin
			if (plan[k].kind == ROW_WRITE) begin
				settle();
				write_reg(plan[k].idx, plan[k].data);
			end else begin
				pace();
				send_item(plan[k].item, plan[k].known, plan[k].known_res);
			end
		end

		// Random phases; the fifth one runs with no idling on either side.
		done_items = 0;
		phase_no = 0;
		while (done_items < 1100) begin
			n = $urandom_range(40, 120);
			no_gaps = (phase_no == 4);
			run_phase(n, phase_no == 0);
			done_items += n;
			phase_no++;
		end
		no_gaps = 1'b0;

		// Drain, then give the block time to show any stray transaction.
		settle();
		repeat (60) @(posedge clk);
		if (fault_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// ------------------------------------------------------------------
	// Receiver: check each accepted result, then pick ready for the next
	// cycle. Once, after a couple hundred results, hold ready low long
	// enough that the output register fills and the block stalls its input.
	// ------------------------------------------------------------------
	initial begin
		int hold_left;
		bit held;
		hold_left = 0;
		held = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (result_valid && result_ready)
				check_result(result);
			if (!held && results_seen >= 200) begin
				held = 1'b1;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else if (no_gaps) begin
				result_ready <= 1'b1;
			end else begin
				result_ready <= ($urandom_range(99) >= 13);
			end
		end
	end

	// Watchdog: a correct run finishes far inside this window.
	initial begin
		#8_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

>>> files.f
sv/sra_pkg.sv
sv/sra_mod.sv
sv/spawn_rate_accumulator.sv
tb/tb_spawn_rate_accumulator.sv
